>>> hdl/mtep_pkg.sv
package mtep_pkg;

    // parse phase codes
    localparam logic [2:0] PH_DELTA   = 3'd0;
    localparam logic [2:0] PH_STATUS  = 3'd1;
    localparam logic [2:0] PH_FIRST   = 3'd2;
    localparam logic [2:0] PH_SECOND  = 3'd3;
    localparam logic [2:0] PH_METALEN = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_CHANNEL = 3'd0;
    localparam logic [2:0] KIND_SYSTEM  = 3'd1;
    localparam logic [2:0] KIND_META    = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NO_RUNNING = 2'd1;
    localparam logic [1:0] ERR_STATUS_FE  = 2'd2;
    localparam logic [1:0] ERR_DELTA_LONG = 2'd3;

    // byte values of interest
    localparam logic [7:0] ST_UNDEFINED   = 8'hfe;
    localparam logic [7:0] ST_META        = 8'hff;
    localparam logic [7:0] META_END_TRACK = 8'h2f;
    localparam logic [3:0] HI_PROGRAM     = 4'hc;
    localparam logic [3:0] HI_PRESSURE    = 4'hd;
    localparam logic [3:0] HI_SYSTEM      = 4'hf;

    localparam int DELTA_W          = 28;
    localparam logic [2:0] DELTA_MAX_GROUPS = 3'd4;

    typedef struct packed {
        logic [2:0]         phase;
        logic [DELTA_W-1:0] delta_acc;
        logic [2:0]         group_cnt;
        logic [7:0]         running_status;
        logic [7:0]         held_first;
        logic [7:0]         meta_remaining;
        logic [7:0]         meta_length;
        logic [31:0]        byte_counter;
    } t_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic [DELTA_W-1:0] delta_ticks;
        logic [7:0]         status;
        logic [7:0]         first_data;
        logic [7:0]         second_data;
        logic [7:0]         meta_length;
        logic               payload_last;
        logic               end_of_track;
        logic [1:0]         error_code;
        logic [31:0]        bytes_consumed;
    } t_result;

endpackage

>>> hdl/mtep_step.sv
module mtep_step (
    input  mtep_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    output mtep_pkg::t_state  o_next,
    output logic              o_emit,
    output mtep_pkg::t_result o_result
);

    logic       do_first;
    logic       last;
    logic       eot;
    logic [2:0] grp;
    logic [mtep_pkg::DELTA_W-1:0] acc_base;

    // one parse step per byte
    always_comb begin
        o_next   = i_state;
        o_emit   = 1'b0;
        o_result = '0;
        do_first = 1'b0;
        last     = 1'b0;
        eot      = 1'b0;
        grp      = 3'd0;
        acc_base = '0;
        o_next.byte_counter = i_state.byte_counter + 32'd1;

        unique case (i_state.phase)
            mtep_pkg::PH_STATUS: begin
                if (!i_byte[7]) begin
                    if (i_state.running_status == 8'd0) begin
                        o_next.phase        = mtep_pkg::PH_DELTA;
                        o_emit              = 1'b1;
                        o_result.kind       = mtep_pkg::KIND_ERROR;
                        o_result.status     = i_state.running_status;
                        o_result.first_data = i_byte;
                        o_result.error_code = mtep_pkg::ERR_NO_RUNNING;
                    end else begin
                        do_first = 1'b1;
                    end
                end else if (i_byte == mtep_pkg::ST_UNDEFINED) begin
                    o_next.phase        = mtep_pkg::PH_DELTA;
                    o_emit              = 1'b1;
                    o_result.kind       = mtep_pkg::KIND_ERROR;
                    o_result.status     = mtep_pkg::ST_UNDEFINED;
                    o_result.first_data = i_byte;
                    o_result.error_code = mtep_pkg::ERR_STATUS_FE;
                end else begin
                    o_next.running_status = i_byte;
                    o_next.phase          = mtep_pkg::PH_FIRST;
                end
            end
            mtep_pkg::PH_FIRST: begin
                do_first = 1'b1;
            end
            mtep_pkg::PH_SECOND: begin
                o_next.phase         = mtep_pkg::PH_DELTA;
                o_emit               = 1'b1;
                o_result.kind        = mtep_pkg::KIND_CHANNEL;
                o_result.status      = i_state.running_status;
                o_result.first_data  = i_state.held_first;
                o_result.second_data = i_byte;
            end
            mtep_pkg::PH_METALEN: begin
                last = (i_byte == 8'd0);
                eot  = last && (i_state.held_first == mtep_pkg::META_END_TRACK);
                o_next.meta_length    = i_byte;
                o_next.meta_remaining = i_byte;
                o_next.phase = last ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
                if (eot) begin
                    o_next.running_status = 8'd0;
                end
                o_emit                = 1'b1;
                o_result.kind         = mtep_pkg::KIND_META;
                o_result.status       = i_state.running_status;
                o_result.first_data   = i_state.held_first;
                o_result.meta_length  = i_byte;
                o_result.payload_last = last;
                o_result.end_of_track = eot;
            end
            mtep_pkg::PH_PAYLOAD: begin
                o_next.meta_remaining = i_state.meta_remaining - 8'd1;
                last = (o_next.meta_remaining == 8'd0);
                eot  = last && (i_state.held_first == mtep_pkg::META_END_TRACK);
                if (last) begin
                    o_next.phase = mtep_pkg::PH_DELTA;
                    if (eot) begin
                        o_next.running_status = 8'd0;
                    end
                end
                o_emit                = 1'b1;
                o_result.kind         = mtep_pkg::KIND_PAYLOAD;
                o_result.status       = i_state.running_status;
                o_result.first_data   = i_state.held_first;
                o_result.second_data  = i_byte;
                o_result.meta_length  = i_state.meta_length;
                o_result.payload_last = last;
                o_result.end_of_track = eot;
            end
            default: begin
                // delta time groups, most significant first
                o_next.phase = mtep_pkg::PH_DELTA;
                acc_base = (i_state.group_cnt == 3'd0) ? '0 : i_state.delta_acc;
                o_next.delta_acc = {acc_base[mtep_pkg::DELTA_W-8:0], i_byte[6:0]};
                grp = i_state.group_cnt + 3'd1;
                o_next.group_cnt = grp;
                if (!i_byte[7]) begin
                    o_next.group_cnt = 3'd0;
                    o_next.phase     = mtep_pkg::PH_STATUS;
                end else if (grp >= mtep_pkg::DELTA_MAX_GROUPS) begin
                    o_next.group_cnt    = 3'd0;
                    o_emit              = 1'b1;
                    o_result.kind       = mtep_pkg::KIND_ERROR;
                    o_result.status     = i_state.running_status;
                    o_result.first_data = i_byte;
                    o_result.error_code = mtep_pkg::ERR_DELTA_LONG;
                end
            end
        endcase

        // first data byte under the status in effect
        if (do_first) begin
            o_next.held_first = i_byte;
            if (i_state.running_status[7:4] == mtep_pkg::HI_PROGRAM ||
                i_state.running_status[7:4] == mtep_pkg::HI_PRESSURE) begin
                o_next.phase        = mtep_pkg::PH_DELTA;
                o_emit              = 1'b1;
                o_result.kind       = mtep_pkg::KIND_CHANNEL;
                o_result.status     = i_state.running_status;
                o_result.first_data = i_byte;
            end else if (i_state.running_status[7:4] == mtep_pkg::HI_SYSTEM) begin
                if (i_state.running_status == mtep_pkg::ST_META) begin
                    o_next.phase = mtep_pkg::PH_METALEN;
                end else begin
                    o_next.phase        = mtep_pkg::PH_DELTA;
                    o_emit              = 1'b1;
                    o_result.kind       = mtep_pkg::KIND_SYSTEM;
                    o_result.status     = i_state.running_status;
                    o_result.first_data = i_byte;
                end
            end else begin
                o_next.phase = mtep_pkg::PH_SECOND;
            end
        end

        o_result.delta_ticks    = o_next.delta_acc;
        o_result.bytes_consumed = o_next.byte_counter;
    end

endmodule

>>> hdl/midi_track_event_parser.sv
// output: a result is registered and appears on the output in the cycle after its byte is taken
// throughput: one byte per cycle; input stalls only while a result waits and the
//   output side stalls
// reset (synchronous, active low): parse restarts at the delta time, running status,
//   delta and byte count cleared, output register emptied
module midi_track_event_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [27:0] o_delta_ticks,
    output logic [7:0]  o_status,
    output logic [7:0]  o_first_data,
    output logic [7:0]  o_second_data,
    output logic [7:0]  o_meta_length,
    output logic        o_payload_last,
    output logic        o_end_of_track,
    output logic [1:0]  o_error_code,
    output logic [31:0] o_bytes_consumed
);

    mtep_pkg::t_state  r_state;
    mtep_pkg::t_state  n_state;
    mtep_pkg::t_result r_res;
    mtep_pkg::t_result n_res;
    logic              r_out_valid;
    logic              emit;
    logic              accept;

    // input beat taken unless a result is held and stalled
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    mtep_step u_step (
        .i_state  (r_state),
        .i_byte   (i_data_byte),
        .o_next   (n_state),
        .o_emit   (emit),
        .o_result (n_res)
    );

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_res <= n_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_res.kind;
    assign o_delta_ticks    = r_res.delta_ticks;
    assign o_status         = r_res.status;
    assign o_first_data     = r_res.first_data;
    assign o_second_data    = r_res.second_data;
    assign o_meta_length    = r_res.meta_length;
    assign o_payload_last   = r_res.payload_last;
    assign o_end_of_track   = r_res.end_of_track;
    assign o_error_code     = r_res.error_code;
    assign o_bytes_consumed = r_res.bytes_consumed;

    // delta group count never holds a full four groups
    a_group_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.group_cnt < mtep_pkg::DELTA_MAX_GROUPS)
        else $error("delta group count out of range");

    // every accepted byte advances the byte count by one
    a_byte_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state.byte_counter == $past(r_state.byte_counter) + 32'd1)
        else $error("byte count did not advance");

    // error code is set exactly on error results
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_kind == mtep_pkg::KIND_ERROR) == (o_error_code != mtep_pkg::ERR_NONE)))
        else $error("error code and kind disagree");

    // end of track only on the last beat of a meta event
    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_track) |-> o_payload_last)
        else $error("end of track without last payload");

endmodule
